FILE: rtl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared definitions for the floating-point format converter
// Selector codes and format constants used by the converter datapath and
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

  // Width of the conversion selector and of the operand / result words.
  localparam int unsigned FuncW = 2;
  localparam int unsigned WordW = 32;

  // Conversion selector codes.
  localparam logic [FuncW-1:0] FUNC_H2S  = 2'd0;  // half to single
  localparam logic [FuncW-1:0] FUNC_S2H  = 2'd1;  // single to half
  localparam logic [FuncW-1:0] FUNC_B2S  = 2'd2;  // bfloat16 to single
  localparam logic [FuncW-1:0] FUNC_S2B  = 2'd3;  // single to bfloat16

  // Format constants.
  localparam logic [7:0]  EXP_BIAS_DIFF = 8'd112;         // 127 - 15
  localparam logic [14:0] HALF_INF      = 15'h7c00;
  localparam logic [30:0] SINGLE_INF    = 31'h7f800000;
  localparam logic [12:0] HALF_RND_TIE  = 13'h1000;
  localparam logic [31:0] BF16_RND_BIAS = 32'h00007fff;
  localparam logic [15:0] BF16_QNAN_BIT = 16'h0040;

endpackage : fbc_pkg

`default_nettype wire

FILE: rtl/fp16_bf16_fp32_converter.sv
// ----------------------------------------------------------------------------
// fp16_bf16_fp32_converter: binary16 / bfloat16 / binary32 format converter
// Two-stage valid/ready pipeline around a combinational conversion datapath.
// ----------------------------------------------------------------------------
// The converter takes one item per cycle while the output is not stalled:
// the operand is captured in an input register, converted in one pass of
// combinational logic, and the result is held in an output register until
// it is taken. func_i selects half to single, single to half, bfloat16 to
// single or single to bfloat16; narrowing conversions round to nearest
// even, and 16-bit results are zero-extended in the low half of
// result_out_o. Each stage advances whenever the stage after it is empty
// or being emptied, so throughput stays at one item per cycle as long as
// the consumer keeps out_ready_i high.
`default_nettype none

module fp16_bf16_fp32_converter import fbc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Input channel.
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [FuncW-1:0] func_i,
  input  wire logic [WordW-1:0] operand_in_i,
  // Output channel.
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [WordW-1:0] result_out_o
);

  logic             s1_valid_q, s1_valid_d;
  logic [FuncW-1:0] s1_func_q;
  logic [WordW-1:0] s1_operand_q;
  logic             s2_valid_q, s2_valid_d;
  logic [WordW-1:0] s2_result_q;
  logic [WordW-1:0] conv_result;
  logic             s2_adv;
  logic             s1_adv;

  // Stage handshakes: a stage loads when the next one can take its item.
  assign s2_adv     = !s2_valid_q || out_ready_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_ready_o = s1_adv;

  assign s1_valid_d = s1_adv ? in_valid_i : s1_valid_q;
  assign s2_valid_d = s2_adv ? s1_valid_q : s2_valid_q;

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_adv) begin
      s1_func_q    <= func_i;
      s1_operand_q <= operand_in_i;
    end
  end

  // Conversion datapath.
  fbc_convert u_convert (
    .func_i    (s1_func_q),
    .operand_i (s1_operand_q),
    .result_o  (conv_result)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_adv) begin
      s2_result_q <= conv_result;
    end
  end

  assign out_valid_o  = s2_valid_q;
  assign result_out_o = s2_result_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // An accepted item always lands in the input register.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item not captured in input register");

  // A converted item moves into the result register when there is room.
  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_adv |=> out_valid_o)
    else $error("converted item lost between stages");

  // A blocked input stage keeps its operand.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_adv |=> s1_valid_q && $stable(s1_operand_q) && $stable(s1_func_q))
    else $error("input register changed while blocked");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !s1_valid_q |=> !out_valid_o)
    else $error("result repeated after it was taken");

endmodule : fp16_bf16_fp32_converter

`default_nettype wire

FILE: rtl/fbc_convert.sv
// ----------------------------------------------------------------------------
// fbc_convert: combinational format conversion datapath
// Performs one of four conversions between binary16, bfloat16 and binary32
// on a single operand, rounding to nearest even where precision is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_convert import fbc_pkg::*; (
  input  wire logic [FuncW-1:0] func_i,
  input  wire logic [WordW-1:0] operand_i,
  output logic      [WordW-1:0] result_o
);

  // Leading zeros of a nonzero 10-bit half mantissa (0..9).
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    n = 4'd9;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        n = 4'(9 - i);
      end
    end
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Half to single.
  // --------------------------------------------------------------------------
  logic [31:0] h2s;
  logic        h_sign;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  h_lz;
  logic [10:0] h_norm;

  assign h_sign = operand_i[15];
  assign h_exp  = operand_i[14:10];
  assign h_man  = operand_i[9:0];
  assign h_lz   = lzc10(h_man);
  // Shift the leading one up to bit 10; it is dropped as the hidden bit.
  assign h_norm = {1'b0, h_man} << (h_lz + 4'd1);

  always_comb begin
    if (h_exp == 5'd0) begin
      if (h_man == 10'd0) begin
        h2s = {h_sign, 31'd0};
      end else begin
        h2s = {h_sign, EXP_BIAS_DIFF - {4'd0, h_lz}, h_norm[9:0], 13'd0};
      end
    end else if (h_exp == 5'h1f) begin
      h2s = {h_sign, SINGLE_INF[30:23], h_man, 13'd0};
    end else begin
      h2s = {h_sign, {3'd0, h_exp} + EXP_BIAS_DIFF, h_man, 13'd0};
    end
  end

  // --------------------------------------------------------------------------
  // Single to half.
  // --------------------------------------------------------------------------
  logic [15:0] s2h;
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_man;
  // Subnormal path.
  logic [4:0]  sub_shift;
  logic [24:0] sub_full;
  logic [24:0] sub_q;
  logic [24:0] sub_rem;
  logic [24:0] sub_half;
  logic [10:0] sub_res;
  // Normal path.
  logic [14:0] nrm_base;
  logic [14:0] nrm_res;
  logic        nrm_up;

  assign s_sign = operand_i[31];
  assign s_exp  = operand_i[30:23];
  assign s_man  = operand_i[22:0];

  // Shift of 14..24 is used only for exponents 102..112.
  assign sub_shift = 5'(8'd126 - s_exp);
  assign sub_full  = {2'b01, s_man};
  assign sub_q     = sub_full >> sub_shift;
  assign sub_rem   = sub_full & ((25'd1 << sub_shift) - 25'd1);
  assign sub_half  = 25'd1 << (sub_shift - 5'd1);

  always_comb begin
    if ((sub_rem > sub_half) || ((sub_rem == sub_half) && sub_q[0])) begin
      sub_res = sub_q[10:0] + 11'd1;
    end else begin
      sub_res = sub_q[10:0];
    end
  end

  // A carry out of the mantissa bumps the exponent, reaching infinity at most.
  assign nrm_base = {5'(s_exp - EXP_BIAS_DIFF), s_man[22:13]};
  assign nrm_up   = (s_man[12:0] > HALF_RND_TIE) ||
                    ((s_man[12:0] == HALF_RND_TIE) && s_man[13]);
  assign nrm_res  = nrm_base + {14'd0, nrm_up};

  always_comb begin
    if (s_exp == 8'hff) begin
      if (s_man == 23'd0) begin
        s2h = {s_sign, HALF_INF};
      end else begin
        s2h = {s_sign, HALF_INF | {5'd0, s_man[22:13]} | 15'd1};
      end
    end else if (s_exp >= 8'd143) begin
      s2h = {s_sign, HALF_INF};
    end else if (s_exp <= 8'd112) begin
      if (s_exp < 8'd102) begin
        s2h = {s_sign, 15'd0};
      end else begin
        s2h = {s_sign, 4'd0, sub_res};
      end
    end else begin
      s2h = {s_sign, nrm_res};
    end
  end

  // --------------------------------------------------------------------------
  // Single to bfloat16.
  // --------------------------------------------------------------------------
  logic [15:0] s2b;
  logic [31:0] bf_sum;

  assign bf_sum = operand_i + BF16_RND_BIAS + {31'd0, operand_i[16]};

  always_comb begin
    if ((s_exp == 8'hff) && (s_man != 23'd0)) begin
      s2b = operand_i[31:16] | BF16_QNAN_BIT;
    end else begin
      s2b = bf_sum[31:16];
    end
  end

  // --------------------------------------------------------------------------
  // Result selection.
  // --------------------------------------------------------------------------
  always_comb begin
    case (func_i)
      FUNC_H2S: result_o = h2s;
      FUNC_S2H: result_o = {16'd0, s2h};
      FUNC_B2S: result_o = {operand_i[15:0], 16'd0};
      FUNC_S2B: result_o = {16'd0, s2b};
      default:  result_o = {16'd0, s2b};
    endcase
  end

endmodule : fbc_convert

`default_nettype wire
